### rtl/core/rtsr_pkg.sv
package rtsr_pkg;

    // Widths of the record fields, fixed by the interface.
    localparam int KEY_W  = 32;
    localparam int DATA_W = 32;
    localparam int POS_W  = 5;
    localparam int FILL_W = 6;

    typedef logic [1:0] t_command;
    typedef logic [1:0] t_status;

    localparam t_command CMD_INSERT = 2'd0;
    localparam t_command CMD_SEARCH = 2'd1;
    localparam t_command CMD_READ   = 2'd2;
    localparam t_command CMD_REMOVE = 2'd3;

    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_FULL      = 2'd1;
    localparam t_status ST_NOT_FOUND = 2'd2;
    localparam t_status ST_EMPTY     = 2'd3;

endpackage

### rtl/core/record_table_search_remove.sv
// Record table: an unsorted list of key and payload records held in one memory.
// The input channel (i_in_valid / o_in_stall) carries one command per transaction:
// insert, search by key, read by position or remove by key. The output channel
// (o_out_valid / i_out_stall) returns exactly one result transaction per command.
// The configuration channel (i_cfg_valid / o_cfg_ready) writes remove_mode and is
// always ready; it should only be used while the block is idle.
// Commands are handled one at a time and o_in_stall is high while one is in work.
// Insert writes the memory as it is accepted; read passes through S_READ. Search
// scans from position 0 and stops at the first match, or after all N entries on
// a miss. Remove scans the same way, then in S_SHIFT moves the last entry into the
// hole h or copies each later entry down by one; N is the fill count. The block is
// ready for the next command in the cycle after its result is loaded. The
// single-port-read memory and one key comparator visit one entry per cycle, and a
// shift removal copies one entry per cycle.
// The result sits in an output register, so a new command is accepted while an
// earlier result is still waiting for the receiver.
// When i_out_stall is high the result holds; a finished command waits in its
// last step until the output register is free.
// Reset (synchronous, active low) empties the table and clears remove_mode to
// zero. No clearing pass runs: entries beyond the fill count are never used.
module record_table_search_remove
    import rtsr_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  t_command            i_command,
    input  logic [KEY_W-1:0]    i_key,
    input  logic [DATA_W-1:0]   i_payload,
    input  logic [POS_W-1:0]    i_position,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output t_status             o_status,
    output logic [POS_W-1:0]    o_found_position,
    output logic [KEY_W-1:0]    o_key_out,
    output logic [DATA_W-1:0]   o_payload_out,
    output logic [FILL_W-1:0]   o_fill_count,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic                i_cfg_remove_mode
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = (CW > FILL_W) ? CW : FILL_W;
    localparam int MW = KEY_W + DATA_W;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_READ  = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_SHIFT = 3'd3;
    localparam logic [2:0] S_DONE  = 3'd4;

    // Record memory: key in the upper half, payload in the lower half.
    logic [MW-1:0]      r_mem [CAPACITY];
    logic [MW-1:0]      r_mem_q;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [MW-1:0]      mem_wdata;
    logic [AW-1:0]      mem_raddr;

    logic [2:0]         r_state, n_state;
    logic [CW-1:0]      r_count, n_count;
    logic               r_mode, n_mode;
    t_command           r_cmd, n_cmd;
    logic [KEY_W-1:0]   r_key, n_key;
    // Next address to read, and whether r_mem_q holds a pending read.
    logic [CW-1:0]      r_ridx, n_ridx;
    logic               r_qv, n_qv;
    logic [AW-1:0]      r_qidx, n_qidx;
    logic [AW-1:0]      r_dst, n_dst;
    t_status            r_res_status, n_res_status;
    logic [AW-1:0]      r_res_pos, n_res_pos;
    logic [KEY_W-1:0]   r_res_key, n_res_key;
    logic [DATA_W-1:0]  r_res_pay, n_res_pay;
    logic               r_out_valid, n_out_valid;
    t_status            r_out_status, n_out_status;
    logic [POS_W-1:0]   r_out_pos, n_out_pos;
    logic [KEY_W-1:0]   r_out_key, n_out_key;
    logic [DATA_W-1:0]  r_out_pay, n_out_pay;
    logic [FILL_W-1:0]  r_out_fill, n_out_fill;

    logic [EW-1:0]      pos_ext;
    logic [EW-1:0]      cnt_ext;
    logic [EW-1:0]      res_pos_ext;
    logic               pos_ok;
    logic               key_hit;

    assign pos_ext     = EW'(i_position);
    assign cnt_ext     = EW'(r_count);
    assign res_pos_ext = EW'(r_res_pos);
    assign pos_ok      = pos_ext < cnt_ext;

    // The one comparator, shared by search and remove.
    assign key_hit = r_qv && (r_mem_q[MW-1:DATA_W] == r_key);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_mem_q <= r_mem[mem_raddr];
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_mode       = r_mode;
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_ridx       = r_ridx;
        n_qv         = r_qv;
        n_qidx       = r_qidx;
        n_dst        = r_dst;
        n_res_status = r_res_status;
        n_res_pos    = r_res_pos;
        n_res_key    = r_res_key;
        n_res_pay    = r_res_pay;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_pos    = r_out_pos;
        n_out_key    = r_out_key;
        n_out_pay    = r_out_pay;
        n_out_fill   = r_out_fill;
        mem_we       = 1'b0;
        mem_waddr    = r_dst;
        mem_wdata    = r_mem_q;
        mem_raddr    = r_ridx[AW-1:0];

        if (i_cfg_valid) begin
            n_mode = i_cfg_remove_mode;
        end
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                mem_raddr = pos_ext[AW-1:0];
                if (i_in_valid) begin
                    n_cmd        = i_command;
                    n_key        = i_key;
                    n_ridx       = '0;
                    n_qv         = 1'b0;
                    n_res_status = ST_OK;
                    n_res_pos    = '0;
                    n_res_key    = '0;
                    n_res_pay    = '0;
                    case (i_command)
                        CMD_INSERT: begin
                            if (r_count < CW'(CAPACITY)) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_count[AW-1:0];
                                mem_wdata = {i_key, i_payload};
                                n_res_pos = r_count[AW-1:0];
                                n_count   = r_count + CW'(1);
                            end else begin
                                n_res_status = ST_FULL;
                            end
                            n_state = S_DONE;
                        end
                        CMD_READ: begin
                            if (pos_ok) begin
                                n_res_pos = pos_ext[AW-1:0];
                                n_state   = S_READ;
                            end else begin
                                n_res_status = ST_EMPTY;
                                n_state      = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_SCAN;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_res_key = r_mem_q[MW-1:DATA_W];
                n_res_pay = r_mem_q[DATA_W-1:0];
                n_state   = S_DONE;
            end
            S_SCAN: begin
                if (key_hit) begin
                    n_res_pos = r_qidx;
                    n_res_key = r_mem_q[MW-1:DATA_W];
                    n_res_pay = r_mem_q[DATA_W-1:0];
                    n_qv      = 1'b0;
                    if (r_cmd == CMD_REMOVE) begin
                        // The hole is filled from the last entry, or from
                        // each later entry in turn.
                        n_dst   = r_qidx;
                        n_ridx  = r_mode ? (CW'(r_qidx) + CW'(1)) : (r_count - CW'(1));
                        n_state = S_SHIFT;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (r_ridx < r_count) begin
                    n_qv   = 1'b1;
                    n_qidx = r_ridx[AW-1:0];
                    n_ridx = r_ridx + CW'(1);
                end else if (r_qv) begin
                    n_qv = 1'b0;
                end else begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end
            end
            S_SHIFT: begin
                if (r_qv) begin
                    mem_we = 1'b1;
                    n_dst  = r_dst + AW'(1);
                end
                if (r_ridx < r_count) begin
                    n_qv   = 1'b1;
                    n_ridx = r_ridx + CW'(1);
                end else begin
                    n_qv = 1'b0;
                    if (!r_qv) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_pos    = res_pos_ext[POS_W-1:0];
                    n_out_key    = r_res_key;
                    n_out_pay    = r_res_pay;
                    n_out_fill   = cnt_ext[FILL_W-1:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_mode      <= 1'b0;
            r_qv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_mode      <= n_mode;
            r_qv        <= n_qv;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_ridx       <= n_ridx;
        r_qidx       <= n_qidx;
        r_dst        <= n_dst;
        r_res_status <= n_res_status;
        r_res_pos    <= n_res_pos;
        r_res_key    <= n_res_key;
        r_res_pay    <= n_res_pay;
        r_out_status <= n_out_status;
        r_out_pos    <= n_out_pos;
        r_out_key    <= n_out_key;
        r_out_pay    <= n_out_pay;
        r_out_fill   <= n_out_fill;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out_status;
    assign o_found_position = r_out_pos;
    assign o_key_out        = r_out_key;
    assign o_payload_out    = r_out_pay;
    assign o_fill_count     = r_out_fill;

endmodule

### rtl/core/rtsr_checker.sv
module rtsr_checker
    import rtsr_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input t_status             o_status,
    input logic [POS_W-1:0]    o_found_position,
    input logic [KEY_W-1:0]    o_key_out,
    input logic [DATA_W-1:0]   o_payload_out,
    input logic [FILL_W-1:0]   o_fill_count
);

    // A stalled result keeps its contents.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_status) && $stable(o_found_position)
             && $stable(o_key_out) && $stable(o_payload_out) && $stable(o_fill_count)))
        else $error("stalled result changed");

    // Every accepted command moves the block out of idle, which raises o_in_stall.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("command accepted without entering work");

    // Failed commands report a zero position and zero record.
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && ((o_status == ST_FULL) || (o_status == ST_NOT_FOUND)
                         || (o_status == ST_EMPTY)))
            |-> ((o_found_position == '0) && (o_key_out == '0) && (o_payload_out == '0)))
        else $error("failed command returned a record");

    // The fill count never exceeds the table size.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((CAPACITY > 63) || (32'(o_fill_count) <= 32'(CAPACITY))))
        else $error("fill count beyond capacity");

endmodule

bind record_table_search_remove rtsr_checker #(.CAPACITY(CAPACITY)) u_rtsr_checker (.*);

### dv/tb_top.sv
module tb_top;
    import rtsr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The table depth used for this run. The model of the table below is sized from it.
    localparam int TABLE_DEPTH = 32;

    // One result transaction as the block reports it.
    typedef struct packed {
        t_status             status;
        logic [POS_W-1:0]    position;
        logic [KEY_W-1:0]    key;
        logic [DATA_W-1:0]   payload;
        logic [FILL_W-1:0]   fill;
    } t_record_result;

    // Ports of the block. Every input starts at a known value before the first edge.
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_in_valid = 1'b0;
    logic                o_in_stall;
    t_command            i_command = CMD_INSERT;
    logic [KEY_W-1:0]    i_key = '0;
    logic [DATA_W-1:0]   i_payload = '0;
    logic [POS_W-1:0]    i_position = '0;
    logic                o_out_valid;
    logic                i_out_stall = 1'b0;
    t_status             o_status;
    logic [POS_W-1:0]    o_found_position;
    logic [KEY_W-1:0]    o_key_out;
    logic [DATA_W-1:0]   o_payload_out;
    logic [FILL_W-1:0]   o_fill_count;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_remove_mode = 1'b0;

    // Our own copy of the table contents, the fill count and the removal mode.
    logic [KEY_W-1:0]    table_keys [TABLE_DEPTH];
    logic [DATA_W-1:0]   table_payloads [TABLE_DEPTH];
    int                  table_count = 0;
    logic                table_remove_mode = 1'b0;

    // Results predicted for accepted commands, oldest first.
    t_record_result      pending_results [$];
    int                  fail_count = 0;

    // Sender burst state. in_valid_up mirrors what was last scheduled on i_in_valid.
    int                  burst_left = 0;
    bit                  in_valid_up = 1'b0;

    // Receiver stall pattern state.
    int                  rx_style = 0;
    int                  rx_phase_left = 0;
    int                  rx_run_left = 0;
    bit                  rx_hold = 1'b0;

    record_table_search_remove #(
        .CAPACITY (TABLE_DEPTH)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_key             (i_key),
        .i_payload         (i_payload),
        .i_position        (i_position),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_found_position  (o_found_position),
        .o_key_out         (o_key_out),
        .o_payload_out     (o_payload_out),
        .o_fill_count      (o_fill_count),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_remove_mode (i_cfg_remove_mode)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // The slowest correct run is well under a millisecond; this bound is several times that.
    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Returns the first filled position holding the key, or -1 when no filled entry matches.
    function automatic int find_first_key(input logic [KEY_W-1:0] key);
        for (int i = 0; i < table_count; i++) begin
            if (table_keys[i] == key) begin
                return i;
            end
        end
        return -1;
    endfunction

    // Applies one command to the table copy and returns the result the block must report.
    function automatic t_record_result apply_table_command(input t_command cmd,
                                                           input logic [KEY_W-1:0] key,
                                                           input logic [DATA_W-1:0] payload,
                                                           input logic [POS_W-1:0] pos);
        t_record_result res;
        int hit;
        int last;
        res = '0;
        res.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (table_count < TABLE_DEPTH) begin
                    table_keys[table_count] = key;
                    table_payloads[table_count] = payload;
                    res.position = table_count[POS_W-1:0];
                    table_count++;
                end else begin
                    res.status = ST_FULL;
                end
            end
            CMD_SEARCH: begin
                hit = find_first_key(key);
                if (hit >= 0) begin
                    res.position = hit[POS_W-1:0];
                    res.key = table_keys[hit];
                    res.payload = table_payloads[hit];
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
            CMD_READ: begin
                if (int'(pos) < table_count) begin
                    res.position = pos;
                    res.key = table_keys[pos];
                    res.payload = table_payloads[pos];
                end else begin
                    res.status = ST_EMPTY;
                end
            end
            default: begin
                hit = find_first_key(key);
                if (hit >= 0) begin
                    last = table_count - 1;
                    res.position = hit[POS_W-1:0];
                    res.key = table_keys[hit];
                    res.payload = table_payloads[hit];
                    if (table_remove_mode == 1'b0) begin
                        // The last record fills the hole; removing the last one only shrinks.
                        table_keys[hit] = table_keys[last];
                        table_payloads[hit] = table_payloads[last];
                    end else begin
                        // Everything above the hole moves down by one position.
                        for (int j = hit; j < last; j++) begin
                            table_keys[j] = table_keys[j + 1];
                            table_payloads[j] = table_payloads[j + 1];
                        end
                    end
                    table_count = last;
                end else begin
                    res.status = ST_NOT_FOUND;
                end
            end
        endcase
        res.fill = table_count[FILL_W-1:0];
        return res;
    endfunction

    // Sends one command transaction. The sender works in bursts, and valid drops between
    // bursts. Valid stays high after acceptance so that back-to-back commands inside a
    // burst need no idle gap. The prediction is made at the edge where the command is
    // accepted, so the table copy always matches the block's order.
    task automatic send_command(input t_command cmd, input logic [KEY_W-1:0] key,
                                input logic [DATA_W-1:0] payload,
                                input logic [POS_W-1:0] pos);
        int gap;
        if (burst_left == 0) begin
            if (in_valid_up) begin
                i_in_valid <= 1'b0;
                in_valid_up = 1'b0;
            end
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
            // Mostly short bursts, now and then a long stretch without any gap.
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
        end
        burst_left--;
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_key <= key;
        i_payload <= payload;
        i_position <= pos;
        in_valid_up = 1'b1;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        pending_results.push_back(apply_table_command(cmd, key, payload, pos));
    endtask

    // Holds the sender off until every outstanding result has been returned.
    task automatic wait_for_results();
        if (in_valid_up) begin
            i_in_valid <= 1'b0;
            in_valid_up = 1'b0;
        end
        burst_left = 0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Writes the removal mode. The block is brought to idle first, since the register
    // may only change between commands.
    task automatic write_remove_mode(input logic mode);
        wait_for_results();
        i_cfg_valid <= 1'b1;
        i_cfg_remove_mode <= mode;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        table_remove_mode = mode;
        i_cfg_valid <= 1'b0;
    endtask

    // Picks a key: mostly one already in the table so that searches and removals hit,
    // otherwise one from a small pool that produces duplicates, or a fully random word.
    function automatic logic [KEY_W-1:0] pick_key();
        int roll;
        roll = $urandom_range(0, 99);
        if (table_count > 0 && roll < 65) begin
            return table_keys[$urandom_range(0, table_count - 1)];
        end else if (roll < 85) begin
            return KEY_W'($urandom_range(0, 15));
        end
        return $urandom;
    endfunction

    // Commands on a table that has never been written: every lookup must miss.
    task automatic test_empty_table();
        send_command(CMD_READ, '0, '0, '0);
        send_command(CMD_READ, '1, '1, '1);
        send_command(CMD_SEARCH, '0, '0, '0);
        send_command(CMD_REMOVE, '1, '0, '0);
    endtask

    // Field extremes, duplicate keys, reads at and past the fill count, and removal by
    // moving the last record into the hole, including removal of the last record itself.
    task automatic test_basic_records();
        write_remove_mode(1'b0);
        send_command(CMD_INSERT, 32'h0000_0000, 32'h0000_0000, 5'd0);
        send_command(CMD_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd31);
        send_command(CMD_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 5'd10);
        send_command(CMD_INSERT, 32'h0000_0000, 32'h1234_5678, 5'd21);
        send_command(CMD_SEARCH, 32'h0000_0000, '0, '0);
        send_command(CMD_SEARCH, 32'hFFFF_FFFF, '0, '0);
        send_command(CMD_READ, '0, '0, 5'd2);
        send_command(CMD_READ, '0, '0, 5'd4);
        send_command(CMD_READ, '0, '0, 5'd31);
        send_command(CMD_REMOVE, 32'h0000_0000, '0, '0);
        send_command(CMD_READ, '0, '0, 5'd0);
        send_command(CMD_SEARCH, 32'h0000_0000, '0, '0);
        send_command(CMD_REMOVE, 32'hA5A5_A5A5, '0, '0);
        send_command(CMD_SEARCH, 32'hA5A5_A5A5, '0, '0);
        send_command(CMD_REMOVE, 32'h0001_2345, '0, '0);
    endtask

    // Fills the table to capacity, then checks that further inserts report full and
    // leave the table untouched, and that an insert succeeds again after a removal.
    task automatic test_full_table();
        while (table_count < TABLE_DEPTH) begin
            send_command(CMD_INSERT, $urandom, $urandom, POS_W'($urandom_range(0, 31)));
        end
        send_command(CMD_INSERT, $urandom, $urandom, '0);
        send_command(CMD_INSERT, '1, '1, '1);
        send_command(CMD_READ, '0, '0, 5'd31);
        send_command(CMD_SEARCH, table_keys[TABLE_DEPTH - 1], '0, '0);
        send_command(CMD_REMOVE, table_keys[5], '0, '0);
        send_command(CMD_READ, '0, '0, 5'd5);
        send_command(CMD_INSERT, $urandom, $urandom, '0);
    endtask

    // Shift removal on a full table: the longest shift from position 0, removal of the
    // last record, and one from the middle.
    task automatic test_shift_removal();
        write_remove_mode(1'b1);
        send_command(CMD_REMOVE, table_keys[0], '0, '0);
        send_command(CMD_READ, '0, '0, 5'd0);
        send_command(CMD_READ, '0, '0, 5'd30);
        send_command(CMD_REMOVE, table_keys[table_count - 1], '0, '0);
        send_command(CMD_REMOVE, table_keys[table_count / 2], '0, '0);
        send_command(CMD_READ, '0, '0, POS_W'(table_count / 2));
        send_command(CMD_READ, '0, '0, POS_W'(table_count));
    endtask

    // Random traffic. A growing phase favors inserts so the table reaches full; a
    // shrinking phase favors removals so it drains towards empty.
    task automatic test_random_traffic(input int n_items, input bit grow);
        int roll;
        t_command cmd;
        logic [POS_W-1:0] pos;
        for (int n = 0; n < n_items; n++) begin
            roll = $urandom_range(0, 99);
            if (roll < (grow ? 45 : 15)) begin
                cmd = CMD_INSERT;
            end else if (roll < (grow ? 65 : 35)) begin
                cmd = CMD_SEARCH;
            end else if (roll < (grow ? 80 : 50)) begin
                cmd = CMD_READ;
            end else begin
                cmd = CMD_REMOVE;
            end
            if (table_count > 0 && $urandom_range(0, 99) < 70) begin
                pos = POS_W'($urandom_range(0, table_count - 1));
            end else begin
                pos = POS_W'($urandom_range(0, 31));
            end
            send_command(cmd, (cmd == CMD_INSERT && $urandom_range(0, 1)) ? $urandom
                                                                          : pick_key(),
                         $urandom, pos);
        end
    endtask

    // Result side. A result transaction is taken at an edge where valid is high and our
    // stall is low, both as they stood before the edge. The stall pattern switches between
    // styles: no stall at all, random stalls, or alternating runs of stall and no stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_stall == 1'b0) begin
            if (pending_results.size() == 0) begin
                $error("result transaction with no command outstanding");
                fail_count++;
            end else begin
                if (o_status !== pending_results[0].status) begin
                    $error("status mismatch: expected %0d, actual %0d",
                           pending_results[0].status, o_status);
                    fail_count++;
                end
                if (o_found_position !== pending_results[0].position) begin
                    $error("found_position mismatch: expected %0d, actual %0d",
                           pending_results[0].position, o_found_position);
                    fail_count++;
                end
                if (o_key_out !== pending_results[0].key) begin
                    $error("key_out mismatch: expected %08h, actual %08h",
                           pending_results[0].key, o_key_out);
                    fail_count++;
                end
                if (o_payload_out !== pending_results[0].payload) begin
                    $error("payload_out mismatch: expected %08h, actual %08h",
                           pending_results[0].payload, o_payload_out);
                    fail_count++;
                end
                if (o_fill_count !== pending_results[0].fill) begin
                    $error("fill_count mismatch: expected %0d, actual %0d",
                           pending_results[0].fill, o_fill_count);
                    fail_count++;
                end
                void'(pending_results.pop_front());
            end
        end

        if (rx_phase_left == 0) begin
            rx_style = $urandom_range(0, 2);
            rx_phase_left = $urandom_range(50, 300);
        end
        rx_phase_left--;
        case (rx_style)
            0: i_out_stall <= 1'b0;
            1: i_out_stall <= ($urandom_range(0, 99) < 35);
            default: begin
                if (rx_run_left == 0) begin
                    rx_hold = !rx_hold;
                    rx_run_left = rx_hold ? $urandom_range(1, 15) : $urandom_range(1, 8);
                end
                rx_run_left--;
                i_out_stall <= rx_hold;
            end
        endcase
    end

    // Test sequence. Reset is held first, the directed tests run next, and then six random
    // phases alternate the removal mode, with two growing phases before each shrinking one.
    // Each mode change drains the block, which also exercises a full pause of the sender.
    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_table();
        test_basic_records();
        test_full_table();
        test_shift_removal();
        for (int p = 0; p < 6; p++) begin
            write_remove_mode(p[0]);
            test_random_traffic(115, (p % 3) != 2);
        end

        // Let the last results come back, then give the block time to show anything extra.
        wait_for_results();
        repeat (100) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never returned", pending_results.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/rtsr_pkg.sv
rtl/core/record_table_search_remove.sv
rtl/core/rtsr_checker.sv
dv/tb_top.sv
